/* design/cossim_pkg.sv */
`default_nettype none
package cossim_pkg;

    localparam int SUM_W = 48;
    localparam int ROOT_W = 24;
    localparam int PROD_W = 48;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = 1;
    localparam int ONE_Q14 = 16384;

    typedef struct packed {
        logic signed [15:0] left_element;
        logic signed [15:0] right_element;
        logic               last_element;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] similarity;
        logic               zero_norm;
    } out_word_t;

    // One finished vector, handed from the accumulator to the divide engine.
    typedef struct packed {
        logic signed [SUM_W-1:0] dot_sum;
        logic signed [SUM_W-1:0] left_norm_sum;
        logic signed [SUM_W-1:0] right_norm_sum;
    } job_t;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] acc,
        input logic signed [31:0]      term
    );
        logic signed [SUM_W:0] s;
        s = {acc[SUM_W-1], acc} + {{(SUM_W-31){term[31]}}, term};
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s[SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* design/cossim_front.sv */
`default_nettype none
module cossim_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cossim_pkg::in_word_t s_word,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output cossim_pkg::job_t        job,
    output logic                    job_valid,
    input  wire logic               job_ready
);

    // Products are registered before they reach the saturating adders.
    logic signed [31:0] dot_prod_reg, left_prod_reg, right_prod_reg;
    logic               prod_valid_reg, prod_last_reg;
    logic signed [cossim_pkg::SUM_W-1:0] dot_reg, left_reg, right_reg;
    logic signed [cossim_pkg::SUM_W-1:0] dot_next, left_next, right_next;
    logic               stall;

    // The stage holding a last product can only move if the queue has room.
    assign stall = prod_valid_reg && prod_last_reg && !job_ready;
    assign s_ready = !stall;

    assign dot_next   = cossim_pkg::sat_add(dot_reg, dot_prod_reg);
    assign left_next  = cossim_pkg::sat_add(left_reg, left_prod_reg);
    assign right_next = cossim_pkg::sat_add(right_reg, right_prod_reg);

    assign job.dot_sum        = dot_next;
    assign job.left_norm_sum  = left_next;
    assign job.right_norm_sum = right_next;
    assign job_valid = prod_valid_reg && prod_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            dot_reg   <= '0;
            left_reg  <= '0;
            right_reg <= '0;
        end else if (!stall) begin
            prod_valid_reg <= s_valid;
            prod_last_reg  <= s_word.last_element;
            if (prod_valid_reg) begin
                if (prod_last_reg) begin
                    dot_reg   <= '0;
                    left_reg  <= '0;
                    right_reg <= '0;
                end else begin
                    dot_reg   <= dot_next;
                    left_reg  <= left_next;
                    right_reg <= right_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            dot_prod_reg   <= s_word.left_element * s_word.right_element;
            left_prod_reg  <= s_word.left_element * s_word.left_element;
            right_prod_reg <= s_word.right_element * s_word.right_element;
        end
    end

endmodule
`default_nettype wire

/* design/cossim_queue.sv */
`default_nettype none
module cossim_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cossim_pkg::job_t wr_job,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    output cossim_pkg::job_t      rd_job,
    output logic                  rd_valid,
    input  wire logic             rd_ready
);

    cossim_pkg::job_t entry_reg [cossim_pkg::QUEUE_DEPTH];
    logic [cossim_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [cossim_pkg::QUEUE_AW:0]   count_reg;
    logic do_wr, do_rd;

    assign wr_ready = count_reg < (cossim_pkg::QUEUE_AW+1)'(cossim_pkg::QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_job   = entry_reg[rd_ptr_reg];
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd) count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) entry_reg[wr_ptr_reg] <= wr_job;
    end

endmodule
`default_nettype wire

/* design/cossim_back.sv */
`default_nettype none
module cossim_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cossim_pkg::job_t  job,
    input  wire logic              job_valid,
    output logic                   job_ready,
    output cossim_pkg::out_word_t  m_word,
    output logic                   m_valid,
    input  wire logic              m_ready
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SQRT = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    localparam int NUM_W = cossim_pkg::SUM_W + 14;

    state_t state_reg;
    logic [5:0] step_reg;
    logic [cossim_pkg::SUM_W-1:0] lrem_reg, rrem_reg, lval_reg, rval_reg;
    logic [cossim_pkg::ROOT_W-1:0] lroot_reg, rroot_reg;
    logic [cossim_pkg::PROD_W-1:0] prod_reg;
    logic [NUM_W-1:0] num_reg, quo_reg;
    logic [cossim_pkg::PROD_W:0] drem_reg;
    logic neg_reg;
    logic [cossim_pkg::ROOT_W+1:0] l_trial, r_trial, l_rem2, r_rem2;
    logic [cossim_pkg::PROD_W:0] d_shift;
    logic [cossim_pkg::SUM_W-1:0] mag;
    logic [15:0] q_clamped;

    // Restoring square root, one result bit per cycle for both norms at once.
    always_comb begin
        l_rem2  = {lrem_reg[cossim_pkg::ROOT_W-1:0], lval_reg[47:46]};
        r_rem2  = {rrem_reg[cossim_pkg::ROOT_W-1:0], rval_reg[47:46]};
        l_trial = {lroot_reg, 2'b01};
        r_trial = {rroot_reg, 2'b01};
        d_shift = {drem_reg[cossim_pkg::PROD_W-1:0], num_reg[NUM_W-1]};
    end

    assign mag = job.dot_sum[cossim_pkg::SUM_W-1] ? -job.dot_sum : job.dot_sum;
    assign q_clamped = (quo_reg > NUM_W'(cossim_pkg::ONE_Q14)) ? 16'(cossim_pkg::ONE_Q14)
                                                              : quo_reg[15:0];
    assign job_ready = state_reg == ST_IDLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid   <= 1'b0;
            step_reg  <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        if (job.left_norm_sum <= 0 || job.right_norm_sum <= 0) begin
                            m_word.similarity <= '0;
                            m_word.zero_norm  <= 1'b1;
                            m_valid   <= 1'b1;
                            state_reg <= ST_OUT;
                        end else begin
                            lval_reg  <= job.left_norm_sum;
                            rval_reg  <= job.right_norm_sum;
                            lrem_reg  <= '0;
                            rrem_reg  <= '0;
                            lroot_reg <= '0;
                            rroot_reg <= '0;
                            num_reg   <= {mag, 14'b0};
                            neg_reg   <= job.dot_sum[cossim_pkg::SUM_W-1];
                            step_reg  <= '0;
                            state_reg <= ST_SQRT;
                        end
                    end
                end
                ST_SQRT: begin
                    lval_reg <= lval_reg << 2;
                    rval_reg <= rval_reg << 2;
                    if ({2'b0, l_rem2} >= {2'b0, l_trial}) begin
                        lrem_reg  <= cossim_pkg::SUM_W'(l_rem2 - l_trial);
                        lroot_reg <= {lroot_reg[cossim_pkg::ROOT_W-2:0], 1'b1};
                    end else begin
                        lrem_reg  <= cossim_pkg::SUM_W'(l_rem2);
                        lroot_reg <= {lroot_reg[cossim_pkg::ROOT_W-2:0], 1'b0};
                    end
                    if ({2'b0, r_rem2} >= {2'b0, r_trial}) begin
                        rrem_reg  <= cossim_pkg::SUM_W'(r_rem2 - r_trial);
                        rroot_reg <= {rroot_reg[cossim_pkg::ROOT_W-2:0], 1'b1};
                    end else begin
                        rrem_reg  <= cossim_pkg::SUM_W'(r_rem2);
                        rroot_reg <= {rroot_reg[cossim_pkg::ROOT_W-2:0], 1'b0};
                    end
                    if (step_reg == 6'(cossim_pkg::ROOT_W - 1)) begin
                        state_reg <= ST_MUL;
                    end
                    step_reg <= step_reg + 1'b1;
                end
                ST_MUL: begin
                    prod_reg  <= lroot_reg * rroot_reg;
                    drem_reg  <= '0;
                    quo_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    num_reg <= num_reg << 1;
                    if (d_shift >= {1'b0, prod_reg}) begin
                        drem_reg <= d_shift - {1'b0, prod_reg};
                        quo_reg  <= {quo_reg[NUM_W-2:0], 1'b1};
                    end else begin
                        drem_reg <= d_shift;
                        quo_reg  <= {quo_reg[NUM_W-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'(NUM_W - 1)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid) begin
                        m_word.similarity <= neg_reg ? -q_clamped : q_clamped;
                        m_word.zero_norm  <= 1'b0;
                        m_valid <= 1'b1;
                    end else if (m_ready) begin
                        m_valid   <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* design/cosine_similarity.sv */
`default_nettype none
// Cosine similarity of two vectors streamed one element pair per word.
// Input channel s_: s_word carries left_element, right_element (signed Q4.12)
// and last_element. One word is taken per cycle while the back end keeps up.
// Output channel m_: one result word per vector, given after its last word:
// similarity in signed Q2.14 (16384 is 1.0) and zero_norm.
// Path from the last input word to the result: the product stage, the queue, 24 square
// root steps for both norms in parallel, the multiply state and 62 restoring divide
// steps. For short vectors the divide loop, not the vector length, sets the rate of results.
// A two-entry queue sits between accumulator and divide engine, so a new vector
// accumulates while the previous one is being divided.
// If m_ready stays low the result holds, the queue fills and then s_ready drops.
// Synchronous active-low reset clears all sums and empties the queue.
module cosine_similarity (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cossim_pkg::in_word_t  s_word,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output cossim_pkg::out_word_t      m_word,
    output logic                       m_valid,
    input  wire logic                  m_ready
);

    cossim_pkg::job_t fr_job, bk_job;
    logic fr_valid, fr_ready, bk_valid, bk_ready;

    cossim_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_word(s_word), .s_valid(s_valid),
        .s_ready(s_ready), .job(fr_job), .job_valid(fr_valid), .job_ready(fr_ready)
    );

    cossim_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .wr_job(fr_job), .wr_valid(fr_valid),
        .wr_ready(fr_ready), .rd_job(bk_job), .rd_valid(bk_valid), .rd_ready(bk_ready)
    );

    cossim_back u_back (
        .aclk(aclk), .aresetn(aresetn), .job(bk_job), .job_valid(bk_valid),
        .job_ready(bk_ready), .m_word(m_word), .m_valid(m_valid), .m_ready(m_ready)
    );

`ifndef SYNTHESIS
    a_sim_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_word.similarity <= 16'sd16384 && m_word.similarity >= -16'sd16384))
        else $error("similarity out of range");
    a_zero_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_word.zero_norm) |-> m_word.similarity == 16'sd0)
        else $error("zero norm with nonzero similarity");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_word)))
        else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire

/* dv/cosine_similarity_checker.sv */
`timescale 1ns / 1ps
module cosine_similarity_checker (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cossim_pkg::in_word_t  s_word,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire cossim_pkg::out_word_t m_word,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    output int                         fail_count,
    output int                         pending_count
);

    localparam logic signed [63:0] SUM_HI = 64'sh7FFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_LO = -64'sh8000_0000_0000;

    logic signed [63:0] dot_acc, lnorm_acc, rnorm_acc;
    cossim_pkg::out_word_t similarity_q[$];

    function automatic logic signed [63:0] clip_add(logic signed [63:0] acc,
                                                     logic signed [63:0] term);
        logic signed [63:0] s;
        s = acc + term;
        if (s > SUM_HI) return SUM_HI;
        if (s < SUM_LO) return SUM_LO;
        return s;
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 46;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic cossim_pkg::out_word_t cosine_of(logic signed [63:0] d,
                                                        logic signed [63:0] l,
                                                        logic signed [63:0] r);
        cossim_pkg::out_word_t o;
        logic [63:0] prod, mag, q;
        if (l <= 0 || r <= 0) begin
            o.similarity = '0;
            o.zero_norm = 1'b1;
        end else begin
            prod = floor_root(l) * floor_root(r);
            mag = d < 0 ? -d : d;
            q = (mag << 14) / prod;
            if (q > cossim_pkg::ONE_Q14) q = cossim_pkg::ONE_Q14;
            o.similarity = d < 0 ? -q[15:0] : q[15:0];
            o.zero_norm = 1'b0;
        end
        return o;
    endfunction

    always @(posedge aclk) begin
        logic signed [63:0] a, b, d, l, r;
        cossim_pkg::out_word_t exp_w;
        if (!aresetn) begin
            dot_acc <= 0;
            lnorm_acc <= 0;
            rnorm_acc <= 0;
            fail_count <= 0;
            pending_count <= 0;
        end else begin
            if (s_valid && s_ready) begin
                a = s_word.left_element;
                b = s_word.right_element;
                d = clip_add(dot_acc, a * b);
                l = clip_add(lnorm_acc, a * a);
                r = clip_add(rnorm_acc, b * b);
                if (s_word.last_element) begin
                    similarity_q.push_back(cosine_of(d, l, r));
                    d = 0;
                    l = 0;
                    r = 0;
                end
                dot_acc <= d;
                lnorm_acc <= l;
                rnorm_acc <= r;
            end
            if (m_valid && m_ready) begin
                if (similarity_q.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result word %h", m_word);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_w = similarity_q.pop_front();
                    if (exp_w !== m_word) begin
                        if (fail_count < 10)
                            $display("mismatch: expected sim %0d zero %0b, got sim %0d zero %0b",
                                     exp_w.similarity, exp_w.zero_norm,
                                     m_word.similarity, m_word.zero_norm);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= similarity_q.size();
        end
    end
endmodule

/* dv/cosine_similarity_tb.sv */
`timescale 1ns / 1ps
module cosine_similarity_tb;

    logic aclk = 0, aresetn = 0;
    cossim_pkg::in_word_t s_word = '0;
    logic s_valid = 0, m_ready = 0;
    logic s_ready, m_valid;
    cossim_pkg::out_word_t m_word;
    int fail_count, pending_count;
    bit stim_done = 0;

    always #10 aclk = ~aclk;

    cosine_similarity i_dut (.aclk, .aresetn, .s_word, .s_valid, .s_ready,
                             .m_word, .m_valid, .m_ready);

    cosine_similarity_checker i_chk (.aclk, .aresetn, .s_word, .s_valid, .s_ready,
                                     .m_word, .m_valid, .m_ready,
                                     .fail_count, .pending_count);

    function automatic int gap_len();
        return ($urandom_range(9) == 0) ? $urandom_range(150) : $urandom_range(2);
    endfunction

    // Element value: extremes, small values, or anything.
    function automatic logic [15:0] pick_element();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // Valid stays high between words sent without a gap.
    task automatic send_word(logic [15:0] a, logic [15:0] b, logic last, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g != 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_word <= '{left_element: a, right_element: b, last_element: last};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Vector of n words; mode 1 repeats one pair, mode 2 negates right.
    task automatic send_vector(int n, int mode, bit gaps);
        logic [15:0] a, b;
        a = pick_element();
        b = pick_element();
        for (int i = 0; i < n; i++) begin
            if (mode == 0) begin
                a = pick_element();
                b = pick_element();
            end else if (mode == 2) begin
                a = pick_element();
                b = -a;
            end
            send_word(a, b, i == n - 1, gaps);
        end
    endtask

    initial begin
        bit quiet;
        forever begin
            @(negedge aclk);
            if (quiet) begin
                m_ready <= 1'b1;
                if ($urandom_range(200) == 0) quiet = 0;
            end else if ($urandom_range(7) == 0) begin
                m_ready <= 1'b0;
                repeat (gap_len()) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(3) != 0);
                if ($urandom_range(100) == 0) quiet = 1;
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // Directed: zero norms, extremes, aligned and opposed, single words and two-word vectors.
        send_word(16'h0000, 16'h0000, 1, 0);
        send_word(16'h1000, 16'h0000, 1, 0);
        send_word(16'h0000, 16'h8000, 1, 0);
        send_word(16'h8000, 16'h8000, 1, 0);
        send_word(16'h7FFF, 16'h8000, 1, 0);
        send_word(16'h7FFF, 16'h7FFF, 1, 0);
        send_word(16'h0001, 16'h0001, 1, 0);
        send_word(16'h0001, 16'hFFFF, 1, 0);
        send_word(16'h1000, 16'h2000, 0, 0);
        send_word(16'h3000, 16'h0001, 1, 0);
        send_word(16'h0003, 16'h0004, 0, 0);
        send_word(16'h0004, 16'hFFFD, 1, 0);
        // Full-scale words over a ten-word vector.
        for (int i = 0; i < 9; i++) send_word(16'h8000, 16'h7FFF, 0, 0);
        send_word(16'h8000, 16'h7FFF, 1, 0);
        // Random vectors, mostly short.
        for (int n = 0; n < 380;) begin
            int len;
            len = ($urandom_range(15) == 0) ? $urandom_range(60, 20) : $urandom_range(6, 1);
            send_vector(len, $urandom_range(3) % 3, $urandom_range(4) != 0);
            n += len;
        end
        s_valid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (pending_count != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("cosine_similarity test passed");
        end else begin
            $display("cosine_similarity test failed");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("cosine_similarity test failed");
        $finish;
    end
endmodule

/* sim.f */
design/cossim_pkg.sv
design/cossim_front.sv
design/cossim_queue.sv
design/cossim_back.sv
design/cosine_similarity.sv
dv/cosine_similarity_checker.sv
dv/cosine_similarity_tb.sv
